// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the decimal compare block
// no dependencies; take in by include where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dcmp_pkg.sv =====
// shared types, order codes and the power of ten table for the decimal compare
// no dependencies
package dcmp_pkg;

   localparam int unsigned POW10_COUNT  = 20;
   localparam int unsigned GAP_IDX_BITS = 5;
   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned HALF_BITS    = 32;
   localparam int unsigned PRODUCT_BITS = 128;

   localparam logic [1:0] ORDER_LESS    = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   // load enables for the two multiplier stages
   typedef struct packed {
      logic load_pp;
      logic load_sum;
   } mul_ctrl_type;

   function automatic logic [WORD_BITS-1:0] pow10(input logic [GAP_IDX_BITS-1:0] idx);
      logic [WORD_BITS-1:0] p;
      case (idx)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         5'd19:   p = 64'd10000000000000000000;
         default: p = 64'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/dcmp_mul.sv =====
// two stage 64 x 64 multiplier: four 32 x 32 partial products, then their sum
// depends on dcmp_pkg
module dcmp_mul (
   input  logic                                   clock,
   input  dcmp_pkg::mul_ctrl_type                 mul_ctrl,
   input  logic [dcmp_pkg::WORD_BITS-1:0]         mul_big,
   input  logic [dcmp_pkg::WORD_BITS-1:0]         mul_pow,
   output logic [dcmp_pkg::PRODUCT_BITS-1:0]      mul_product
);

   localparam int unsigned H = dcmp_pkg::HALF_BITS;
   localparam int unsigned P = dcmp_pkg::PRODUCT_BITS;

   logic [2*H-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [2*H-1:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [P-1:0]   sum_ff, sum_in;

   assign pp_ll_in = mul_big[H-1:0]   * mul_pow[H-1:0];
   assign pp_lh_in = mul_big[H-1:0]   * mul_pow[2*H-1:H];
   assign pp_hl_in = mul_big[2*H-1:H] * mul_pow[H-1:0];
   assign pp_hh_in = mul_big[2*H-1:H] * mul_pow[2*H-1:H];

   // cross terms sit one half word up, the high term a full word up
   assign sum_in = P'(pp_ll_ff)
                 + (P'(pp_lh_ff) << H)
                 + (P'(pp_hl_ff) << H)
                 + {pp_hh_ff, (2*H)'(0)};

   always_ff @(posedge clock) begin
      if (mul_ctrl.load_pp) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
      if (mul_ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign mul_product = sum_ff;

endmodule

// ===== rtl/decimal_compare_64_top.sv =====
// decimal compare top level: orders two scaled decimals, depends on dcmp_pkg and dcmp_mul
// response: a request beat is registered through stages 1, 2, 3 and 4 in order; rsp_valid is the stage 4 valid
// throughput: one beat per cycle while rsp_stall is low; the four stages hold data under stall and fill bubbles
// reset: synchronous active high reset empties every stage; no other state to clear
`include "assert_macros.svh"

module decimal_compare_64_top #(
   parameter int unsigned SIGNIFICAND_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_left_significand,
   input  logic [31:0] req_left_exponent,
   input  logic [63:0] req_right_significand,
   input  logic [31:0] req_right_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_order
);

   localparam int unsigned W = SIGNIFICAND_BITS;
   localparam int unsigned P = dcmp_pkg::PRODUCT_BITS;

   // stage enables: a stage loads when it is empty or its contents move on
   logic en1, en2, en3, en4;

   // stage 1: exponent gap, operand selection, power of ten lookup
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [W-1:0] small1_ff, small2_ff, small3_ff;
   logic [dcmp_pkg::WORD_BITS-1:0] big1_ff, pow1_ff;
   logic        swap1_ff, swap2_ff, swap3_ff;
   logic        far1_ff, far2_ff, far3_ff;
   logic [1:0]  order4_ff;

   logic [W-1:0] ls, rs;
   logic         exp_eq, exp_lt, any_zero, use_one, far_gap;
   logic [32:0]  exp_diff;
   logic [31:0]  gap;
   logic [W-1:0] small1_in;
   logic [dcmp_pkg::WORD_BITS-1:0] big1_in, pow1_in;
   logic         swap1_in, far1_in;

   dcmp_pkg::mul_ctrl_type         mul_ctrl;
   logic [P-1:0]                   product;
   logic [P-1:0]                   small_wide;
   logic [1:0]                     raw_order, order4_in;

   // handshake: stall ripples back only through full stages
   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   // only the low significand bits take part
   assign ls = req_left_significand[W-1:0];
   assign rs = req_right_significand[W-1:0];

   // full width gap so that a span over the whole exponent range never wraps
   assign exp_diff = {req_right_exponent[31], req_right_exponent}
                   - {req_left_exponent[31], req_left_exponent};
   assign exp_eq   = (req_left_exponent == req_right_exponent);
   assign exp_lt   = $signed(req_left_exponent) < $signed(req_right_exponent);
   assign gap      = exp_lt ? exp_diff[31:0] : 32'(-exp_diff);
   assign any_zero = (ls == '0) || (rs == '0);

   // equal exponents or a zero significand compare the raw significands
   assign use_one  = exp_eq || any_zero;
   assign far_gap  = gap >= 32'(dcmp_pkg::POW10_COUNT);
   assign far1_in  = !use_one && far_gap;

   // small is the side with the lower exponent; it is set against big * 10^gap
   // with equal exponents small is the right side, so the sense is reversed too
   assign small1_in = exp_lt ? ls : rs;
   assign big1_in   = dcmp_pkg::WORD_BITS'(exp_lt ? rs : ls);
   assign swap1_in  = !exp_lt;
   assign pow1_in   = (use_one || far_gap) ? dcmp_pkg::WORD_BITS'(1)
                                           : dcmp_pkg::pow10(gap[dcmp_pkg::GAP_IDX_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // payload side band travelling beside the multiplier
   always_ff @(posedge clock) begin
      if (en1) begin
         small1_ff <= small1_in;
         big1_ff   <= big1_in;
         pow1_ff   <= pow1_in;
         swap1_ff  <= swap1_in;
         far1_ff   <= far1_in;
      end
      if (en2) begin
         small2_ff <= small1_ff;
         swap2_ff  <= swap1_ff;
         far2_ff   <= far1_ff;
      end
      if (en3) begin
         small3_ff <= small2_ff;
         swap3_ff  <= swap2_ff;
         far3_ff   <= far2_ff;
      end
      if (en4) begin
         order4_ff <= order4_in;
      end
   end

   // stages 2 and 3: partial products, then their sum
   assign mul_ctrl.load_pp  = en2;
   assign mul_ctrl.load_sum = en3;

   dcmp_mul u_mul (
      .clock       (clock),
      .mul_ctrl    (mul_ctrl),
      .mul_big     (big1_ff),
      .mul_pow     (pow1_ff),
      .mul_product (product)
   );

   // stage 4: exact compare of small against the scaled big side
   assign small_wide = P'(small3_ff);

   always_comb begin
      if (far3_ff) begin
         raw_order = dcmp_pkg::ORDER_LESS;
      end else if (small_wide < product) begin
         raw_order = dcmp_pkg::ORDER_LESS;
      end else if (small_wide == product) begin
         raw_order = dcmp_pkg::ORDER_EQUAL;
      end else begin
         raw_order = dcmp_pkg::ORDER_GREATER;
      end
   end

   // when the right side had the lower exponent the sense is reversed
   always_comb begin
      order4_in = raw_order;
      if (swap3_ff) begin
         case (raw_order)
            dcmp_pkg::ORDER_LESS:    order4_in = dcmp_pkg::ORDER_GREATER;
            dcmp_pkg::ORDER_GREATER: order4_in = dcmp_pkg::ORDER_LESS;
            default:                 order4_in = raw_order;
         endcase
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_order = order4_ff;

   // only the three order codes ever leave the block
   `ASSERT_ALWAYS(a_order_legal, clock, reset,
      !rsp_valid || rsp_order == dcmp_pkg::ORDER_LESS || rsp_order == dcmp_pkg::ORDER_EQUAL
      || rsp_order == dcmp_pkg::ORDER_GREATER, "illegal order code on response")

   // an empty output stage must never back-pressure the requester
   `ASSERT_ALWAYS(a_no_false_stall, clock, reset,
      rsp_valid || !req_stall, "stall raised with an empty output stage")

   // a wide exponent gap can never come out as equal
   `ASSERT_NEXT(a_far_not_equal, clock, reset, v3_ff && far3_ff && en4,
      rsp_order != dcmp_pkg::ORDER_EQUAL, "wide gap compared as equal")

endmodule
